// ===== rtl/core/nsfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the NMEA field extractor.
package nsfe_pkg;

	localparam int HEADER_SKIP     = 7;
	localparam int FRACTION_DIGITS = 4;
	localparam int HL_W            = 3;
	localparam int FD_W            = $clog2(FRACTION_DIGITS + 1);
	localparam int ACC_W           = 39;
	localparam int VAL_W           = ACC_W + 1;
	localparam int SCALE           = 10 ** FRACTION_DIGITS;
	localparam int SCALE_W         = $clog2(SCALE + 1);
	localparam int BV_W            = 8 + SCALE_W;
	localparam int CMDQ_DEPTH      = 2;
	localparam int OUTQ_DEPTH      = 2;

	localparam logic [ACC_W-1:0]   ACC_MAX = {ACC_W{1'b1}};
	localparam logic [SCALE_W-1:0] SCALE_V = SCALE_W'(SCALE);

	// Low byte of the integer part of a saturated accumulator, per kept decimal count.
	localparam logic [7:0] SAT_IP0 = 8'(ACC_MAX);
	localparam logic [7:0] SAT_IP1 = 8'(ACC_MAX / 10);
	localparam logic [7:0] SAT_IP2 = 8'(ACC_MAX / 100);
	localparam logic [7:0] SAT_IP3 = 8'(ACC_MAX / 1000);
	localparam logic [7:0] SAT_IP4 = 8'(ACC_MAX / 10000);
	localparam logic [7:0] SAT_IP5 = 8'(ACC_MAX / 100000);
	localparam logic [7:0] SAT_IP6 = 8'(ACC_MAX / 1000000);

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		KIND_GGA  = 2'd0,
		KIND_GSA  = 2'd1,
		KIND_VTG  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef logic [3:0] qty_t;

	localparam qty_t Q_HOUR   = 4'd0;
	localparam qty_t Q_MIN    = 4'd1;
	localparam qty_t Q_SEC    = 4'd2;
	localparam qty_t Q_LATDEG = 4'd3;
	localparam qty_t Q_LATMIN = 4'd4;
	localparam qty_t Q_NS     = 4'd5;
	localparam qty_t Q_LONDEG = 4'd6;
	localparam qty_t Q_LONMIN = 4'd7;
	localparam qty_t Q_EW     = 4'd8;
	localparam qty_t Q_FIX    = 4'd9;
	localparam qty_t Q_SATS   = 4'd10;
	localparam qty_t Q_ALT    = 4'd11;
	localparam qty_t Q_PDOP   = 4'd12;
	localparam qty_t Q_COURSE = 4'd13;
	localparam qty_t Q_KMH    = 4'd14;

	typedef enum logic [2:0] {
		SRC_MAJOR,
		SRC_MINOR,
		SRC_INT,
		SRC_FLOAT,
		SRC_HEMI
	} src_t;

	// One closed field of interest: the quantities it yields and the raw material for them.
	typedef struct packed {
		qty_t             q0;
		logic [1:0]       cnt;
		logic [ACC_W-1:0] acc;
		logic [FD_W-1:0]  fd;
		logic             neg;
		logic [7:0]       major;
		logic [6:0]       minor;
		logic [7:0]       ip_byte;
		logic [7:0]       hemi;
	} rec_t;

	typedef struct packed {
		qty_t                    quantity;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} result_t;

	function automatic src_t qty_src(input qty_t q);
		src_t s;
		unique case (q) inside
			Q_HOUR, Q_LATDEG, Q_LONDEG: s = SRC_MAJOR;
			Q_MIN:                      s = SRC_MINOR;
			Q_SEC, Q_FIX, Q_SATS:       s = SRC_INT;
			Q_NS, Q_EW:                 s = SRC_HEMI;
			default:                    s = SRC_FLOAT;
		endcase
		return s;
	endfunction

	function automatic logic [SCALE_W-1:0] pow10(input logic [FD_W-1:0] k);
		logic [SCALE_W-1:0] r;
		r = SCALE_W'(1);
		for (int i = 0; i < FRACTION_DIGITS; i++) begin
			if (i < int'(k)) r = SCALE_W'(r * SCALE_W'(10));
		end
		return r;
	endfunction

	function automatic logic [7:0] sat_ip_lo(input logic [FD_W-1:0] k);
		logic [7:0] r;
		unique case (int'(k))
			1:       r = SAT_IP1;
			2:       r = SAT_IP2;
			3:       r = SAT_IP3;
			4:       r = SAT_IP4;
			5:       r = SAT_IP5;
			6:       r = SAT_IP6;
			default: r = SAT_IP0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/nsfe_front.sv =====
`timescale 1ns / 1ps
// Character parser: header skip, field counting, digit accumulation and field records.
module nsfe_front import nsfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] opcode,
	input  logic [7:0] char_in,
	input  logic       start_req,
	output logic       rec_push,
	output rec_t       rec,
	input  logic       rec_full
);

	localparam logic [3:0] FLD_TIME   = 4'd0;
	localparam logic [3:0] FLD_LAT    = 4'd1;
	localparam logic [3:0] FLD_NS     = 4'd2;
	localparam logic [3:0] FLD_LON    = 4'd3;
	localparam logic [3:0] FLD_EW     = 4'd4;
	localparam logic [3:0] FLD_FIX    = 4'd5;
	localparam logic [3:0] FLD_SATS   = 4'd6;
	localparam logic [3:0] FLD_ALT    = 4'd8;
	localparam logic [3:0] FLD_PDOP   = 4'd14;
	localparam logic [3:0] FLD_COURSE = 4'd0;
	localparam logic [3:0] FLD_KMH    = 4'd6;
	localparam logic [3:0] FLD_MAX    = 4'd15;
	localparam logic [3:0] LAT_DEG_N  = 4'd2;
	localparam logic [3:0] LON_DEG_N  = 4'd3;
	localparam logic [3:0] MIN_N      = 4'd7;

	logic [HL_W-1:0]  header_left_q;
	kind_t            kind_q;
	logic [3:0]       field_q;
	logic [3:0]       pos_q;
	logic [ACC_W-1:0] acc_q;
	logic [FD_W-1:0]  fd_q;
	logic             frac_q;
	logic             neg_q;
	logic [7:0]       major_q;
	logic [6:0]       minor_q;
	logic [7:0]       first_q;
	logic [7:0]       int8_q;

	logic             accept;
	logic             is_digit;
	logic [3:0]       dig;
	logic             seg_major;
	logic             seg_minor;
	logic             seg_num;
	logic [3:0]       seg_start;
	logic [3:0]       deg_n;
	logic [ACC_W+3:0] push_sum;
	logic [ACC_W-1:0] acc_dig;
	logic             take_dig;
	logic             active;
	logic [1:0]       rec_cnt;
	qty_t             rec_q0;
	logic [7:0]       ip_lo;

	assign full     = rec_full;
	assign accept   = push && !rec_full;
	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign dig      = 4'(char_in - CH_ZERO);
	assign active   = !start_req && (header_left_q == '0) && (kind_q != KIND_NONE);

	// Fixed-position sub-fields of the GGA time and coordinate fields.
	always_comb begin
		seg_major = 1'b0;
		seg_minor = 1'b0;
		seg_num   = 1'b0;
		seg_start = 4'd0;
		deg_n     = (field_q == FLD_LAT) ? LAT_DEG_N : LON_DEG_N;
		if (kind_q == KIND_GGA && field_q == FLD_TIME) begin
			if (pos_q < 4'd2) begin
				seg_major = 1'b1;
			end else if (pos_q < 4'd4) begin
				seg_minor = 1'b1;
			end else if (pos_q < 4'd6) begin
				seg_num   = 1'b1;
				seg_start = 4'd4;
			end
		end else if (kind_q == KIND_GGA && (field_q == FLD_LAT || field_q == FLD_LON)) begin
			if (pos_q < deg_n) begin
				seg_major = 1'b1;
			end else if (pos_q < deg_n + MIN_N) begin
				seg_num   = 1'b1;
				seg_start = deg_n;
			end
		end else begin
			seg_num = 1'b1;
		end
	end

	// Saturating decimal shift-in: a*10+d clamps at the largest magnitude.
	assign push_sum = (ACC_W+4)'({acc_q, 3'b000}) + (ACC_W+4)'({acc_q, 1'b0}) + (ACC_W+4)'(dig);
	assign acc_dig  = (push_sum > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : push_sum[ACC_W-1:0];
	assign take_dig = is_digit && (!frac_q || (fd_q < FD_W'(FRACTION_DIGITS)));

	always_comb begin
		rec_cnt = 2'd0;
		rec_q0  = Q_HOUR;
		unique case (kind_q)
			KIND_GGA: begin
				case (field_q)
					FLD_TIME: begin rec_q0 = Q_HOUR;   rec_cnt = 2'd3; end
					FLD_LAT:  begin rec_q0 = Q_LATDEG; rec_cnt = 2'd2; end
					FLD_NS:   begin rec_q0 = Q_NS;     rec_cnt = 2'd1; end
					FLD_LON:  begin rec_q0 = Q_LONDEG; rec_cnt = 2'd2; end
					FLD_EW:   begin rec_q0 = Q_EW;     rec_cnt = 2'd1; end
					FLD_FIX:  begin rec_q0 = Q_FIX;    rec_cnt = 2'd1; end
					FLD_SATS: begin rec_q0 = Q_SATS;   rec_cnt = 2'd1; end
					FLD_ALT:  begin rec_q0 = Q_ALT;    rec_cnt = 2'd1; end
					default:  ;
				endcase
			end
			KIND_GSA: begin
				if (field_q == FLD_PDOP) begin
					rec_q0  = Q_PDOP;
					rec_cnt = 2'd1;
				end
			end
			KIND_VTG: begin
				if (field_q == FLD_COURSE) begin
					rec_q0  = Q_COURSE;
					rec_cnt = 2'd1;
				end else if (field_q == FLD_KMH) begin
					rec_q0  = Q_KMH;
					rec_cnt = 2'd1;
				end
			end
			default: ;
		endcase
	end

	// A saturated accumulator no longer holds its integer digits, but its
	// integer part is then a known constant for each count of kept decimals.
	assign ip_lo = (acc_q == ACC_MAX) ? sat_ip_lo(fd_q) : int8_q;

	always_comb begin
		rec.q0      = rec_q0;
		rec.cnt     = rec_cnt;
		rec.acc     = acc_q;
		rec.fd      = fd_q;
		rec.neg     = neg_q;
		rec.major   = major_q;
		rec.minor   = minor_q;
		rec.ip_byte = neg_q ? 8'(8'd0 - ip_lo) : ip_lo;
		rec.hemi    = (pos_q == 4'd0) ? CH_COMMA : first_q;
	end

	assign rec_push = accept && active && (char_in == CH_COMMA) && (rec_cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_left_q <= '0;
			kind_q        <= KIND_NONE;
			field_q       <= 4'd0;
			pos_q         <= 4'd0;
			acc_q         <= '0;
			fd_q          <= '0;
			frac_q        <= 1'b0;
			neg_q         <= 1'b0;
			major_q       <= 8'd0;
			minor_q       <= 7'd0;
			first_q       <= 8'd0;
			int8_q        <= 8'd0;
		end else if (accept) begin
			if (start_req || (active && char_in == CH_COMMA)) begin
				pos_q   <= 4'd0;
				acc_q   <= '0;
				fd_q    <= '0;
				frac_q  <= 1'b0;
				neg_q   <= 1'b0;
				major_q <= 8'd0;
				minor_q <= 7'd0;
				first_q <= 8'd0;
				int8_q  <= 8'd0;
			end
			if (start_req) begin
				kind_q        <= kind_t'(opcode);
				header_left_q <= HL_W'(HEADER_SKIP - 1);
				field_q       <= 4'd0;
			end else if (header_left_q != '0) begin
				header_left_q <= header_left_q - HL_W'(1);
			end else if (kind_q != KIND_NONE) begin
				if (char_in == CH_COMMA) begin
					if (field_q != FLD_MAX) field_q <= field_q + 4'd1;
				end else begin
					if (pos_q == 4'd0) first_q <= char_in;
					if (pos_q != 4'd15) pos_q <= pos_q + 4'd1;
					if (seg_major && is_digit) major_q <= 8'(major_q * 8'd10 + 8'(dig));
					if (seg_minor && is_digit) minor_q <= 7'(minor_q * 7'd10 + 7'(dig));
					if (seg_num) begin
						if (is_digit) begin
							if (take_dig) begin
								acc_q <= acc_dig;
								if (frac_q) begin
									fd_q <= fd_q + FD_W'(1);
								end else begin
									int8_q <= 8'(int8_q * 8'd10 + 8'(dig));
								end
							end
						end else if (char_in == CH_DOT) begin
							frac_q <= 1'b1;
						end else if (char_in == CH_MINUS && pos_q == seg_start) begin
							neg_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fd_q <= FD_W'(FRACTION_DIGITS))
		else $error("kept decimal count beyond the limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && start_req) |=> (header_left_q == HL_W'(HEADER_SKIP - 1) && pos_q == 4'd0))
		else $error("sentence start did not rearm the header skip");

	assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> (kind_q != KIND_NONE && header_left_q == '0))
		else $error("field record outside a supported sentence body");

endmodule

// ===== rtl/core/nsfe_cmd_queue.sv =====
`timescale 1ns / 1ps
// Short queue of field records between the parser and the value unit.
module nsfe_cmd_queue import nsfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic rec_push,
	input  rec_t rec_in,
	output logic rec_full,
	output logic rec_valid,
	output rec_t rec_out,
	input  logic rec_pop
);

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	rec_t             ent_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign rec_full  = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign rec_valid = (cnt_q != '0);
	assign rec_out   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (rec_push) ent_q[wr_ptr_q] <= rec_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (rec_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rec_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (rec_push && !rec_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (rec_pop && !rec_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> !rec_full)
		else $error("record written into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		rec_pop |-> rec_valid)
		else $error("record taken from an empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CMDQ_DEPTH))
		else $error("record count beyond queue depth");

endmodule

// ===== rtl/core/nsfe_back.sv =====
`timescale 1ns / 1ps
// Value unit: scales field records into results and queues them for the consumer.
module nsfe_back import nsfe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rec_valid,
	input  rec_t                    rec,
	output logic                    rec_pop,
	output logic                    empty,
	input  logic                    pop,
	output qty_t                    quantity,
	output logic signed [VAL_W-1:0] value_e4,
	output logic                    last
);

	localparam int PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);
	localparam int FP_W  = ACC_W + SCALE_W;

	logic                     valid_s1;
	logic [1:0]               idx_q;
	qty_t                     q0_s1;
	logic [1:0]               cnt_s1;
	logic [FP_W-1:0]          fprod_s1;
	logic                     neg_s1;
	logic [BV_W-1:0]          major_s1;
	logic [BV_W-1:0]          minor_s1;
	logic [BV_W-1:0]          int_s1;
	logic [7:0]               hemi_s1;

	logic [SCALE_W-1:0]       pw;
	logic [FP_W-1:0]          fprod;
	qty_t                     qty_cur;
	logic                     last_cur;
	logic [ACC_W-1:0]         fsat;
	logic [VAL_W-1:0]         fmag;
	logic [VAL_W-1:0]         val_cur;
	logic                     emit;
	logic                     out_pop;
	logic                     oq_space;
	result_t                  res;

	result_t                  oq_q [OUTQ_DEPTH];
	logic [PTR_W-1:0]         oq_wr_q;
	logic [PTR_W-1:0]         oq_rd_q;
	logic [CNT_W-1:0]         oq_cnt_q;

	// Missing decimals are appended as a multiply by a power of ten.
	assign pw    = pow10(FD_W'(FRACTION_DIGITS) - rec.fd);
	assign fprod = {{SCALE_W{1'b0}}, rec.acc} * {{ACC_W{1'b0}}, pw};

	assign qty_cur  = q0_s1 + qty_t'(idx_q);
	assign last_cur = ((idx_q + 2'd1) == cnt_s1);
	assign fsat     = (fprod_s1 > FP_W'(ACC_MAX)) ? ACC_MAX : fprod_s1[ACC_W-1:0];
	assign fmag     = {1'b0, fsat};

	always_comb begin
		unique case (qty_src(qty_cur))
			SRC_MAJOR: val_cur = VAL_W'(major_s1);
			SRC_MINOR: val_cur = VAL_W'(minor_s1);
			SRC_INT:   val_cur = VAL_W'(int_s1);
			SRC_HEMI:  val_cur = VAL_W'(hemi_s1);
			default:   val_cur = neg_s1 ? VAL_W'(0) - fmag : fmag;
		endcase
	end

	assign out_pop  = pop && !empty;
	assign oq_space = (oq_cnt_q != CNT_W'(OUTQ_DEPTH)) || out_pop;
	assign emit     = valid_s1 && oq_space;
	assign rec_pop  = rec_valid && (!valid_s1 || (emit && last_cur));

	assign res.quantity = qty_cur;
	assign res.value    = val_cur;
	assign res.last     = last_cur;

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			q0_s1    <= rec.q0;
			cnt_s1   <= rec.cnt;
			fprod_s1 <= fprod;
			neg_s1   <= rec.neg;
			major_s1 <= BV_W'(rec.major) * BV_W'(SCALE_V);
			minor_s1 <= BV_W'(rec.minor) * BV_W'(SCALE_V);
			int_s1   <= BV_W'(rec.ip_byte) * BV_W'(SCALE_V);
			hemi_s1  <= rec.hemi;
		end
		if (emit) oq_q[oq_wr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= 2'd0;
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (rec_pop) begin
				valid_s1 <= 1'b1;
				idx_q    <= 2'd0;
			end else if (emit && last_cur) begin
				valid_s1 <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
			if (emit) begin
				oq_wr_q <= (oq_wr_q == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_wr_q + PTR_W'(1);
			end
			if (out_pop) begin
				oq_rd_q <= (oq_rd_q == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : oq_rd_q + PTR_W'(1);
			end
			if (emit && !out_pop) begin
				oq_cnt_q <= oq_cnt_q + CNT_W'(1);
			end else if (out_pop && !emit) begin
				oq_cnt_q <= oq_cnt_q - CNT_W'(1);
			end
		end
	end

	assign empty    = (oq_cnt_q == '0);
	assign quantity = oq_q[oq_rd_q].quantity;
	assign value_e4 = oq_q[oq_rd_q].value;
	assign last     = oq_q[oq_rd_q].last;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (cnt_s1 != 2'd0 && idx_q < cnt_s1))
		else $error("result index outside the record");

	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_cur && !rec_pop) |=> !valid_s1)
		else $error("record kept after its final result");

	assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= CNT_W'(OUTQ_DEPTH))
		else $error("result queue overflow");

endmodule

// ===== rtl/core/nmea_sentence_field_extractor_core.sv =====
`timescale 1ns / 1ps
// Top level of the NMEA sentence field extractor.
//
//   Channel   Direction  Handshake      Fields
//   chars     in         push / full    opcode, char_in, start_req
//   results   out        empty / pop    quantity, value_e4, last
//
// One character is taken per cycle while full is low; the parser updates its field state in that cycle.
// A closing comma of a field of interest queues a record; the value unit scales it in one
// stage and writes one to three results into a two-entry output queue, one per cycle while it
// has space; results pass through the record queue, the scaling stage and the output queue.
// full follows the two-entry record queue: it rises when the consumer stalls, and also when
// commas close fields of interest faster than the one-result-per-cycle value unit drains them.
// Reset (arst_n low) clears parser state and queue pointers and counts; the block behaves
// as unsupported until a sentence start arrives.
module nmea_sentence_field_extractor_core import nsfe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [1:0]              opcode,
	input  logic [7:0]              char_in,
	input  logic                    start_req,
	output logic                    empty,
	input  logic                    pop,
	output logic [3:0]              quantity,
	output logic signed [VAL_W-1:0] value_e4,
	output logic                    last
);

	logic rec_push;
	logic rec_full;
	logic rec_valid;
	logic rec_pop;
	rec_t rec_in;
	rec_t rec_head;

	nsfe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.opcode   (opcode),
		.char_in  (char_in),
		.start_req(start_req),
		.rec_push (rec_push),
		.rec      (rec_in),
		.rec_full (rec_full)
	);

	nsfe_cmd_queue u_cmd_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_push (rec_push),
		.rec_in   (rec_in),
		.rec_full (rec_full),
		.rec_valid(rec_valid),
		.rec_out  (rec_head),
		.rec_pop  (rec_pop)
	);

	nsfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rec_valid(rec_valid),
		.rec      (rec_head),
		.rec_pop  (rec_pop),
		.empty    (empty),
		.pop      (pop),
		.quantity (quantity),
		.value_e4 (value_e4),
		.last     (last)
	);

endmodule
